FILE: hdl/rtll_pkg.sv
package rtll_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 32;
    localparam int RESULT_CAP  = 32;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int LIM_W       = 6;
    localparam int CAP_W       = $clog2(RESULT_CAP + 1);
    localparam int CMP_W0      = (CNT_W > LIM_W) ? CNT_W : LIM_W;
    localparam int CMP_W       = (CMP_W0 > CAP_W) ? CMP_W0 : CAP_W;

    // Request operation codes
    typedef enum logic [1:0] {
        FN_RECORD = 2'd0,
        FN_LOOKUP = 2'd1,
        FN_DUMP   = 2'd2,
        FN_CLEAR  = 2'd3
    } func_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_RESP,
        ST_DUMP
    } state_t;

    // Request transaction
    typedef struct packed {
        logic [1:0]        func;
        logic [7:0]        dev_key;
        logic [7:0]        sub_key_a;
        logic [7:0]        sub_key_b;
        logic [7:0]        route_channel;
        logic signed [7:0] route_slot;
        logic [31:0]       time_now;
        logic [LIM_W-1:0]  dump_limit;
    } in_item_t;

    // Response transaction
    typedef struct packed {
        logic              hit;
        logic [7:0]        out_dev;
        logic [7:0]        out_sub_a;
        logic [7:0]        out_sub_b;
        logic [7:0]        out_channel;
        logic signed [7:0] out_slot;
        logic [31:0]       out_seen;
        logic              last_row;
    } out_item_t;

    // One table entry: key and endpoint
    typedef struct packed {
        logic [7:0]        dev;
        logic [7:0]        sub_a;
        logic [7:0]        sub_b;
        logic [7:0]        channel;
        logic signed [7:0] slot;
        logic [31:0]       seen;
    } entry_t;

    // Table port controls from the sequencer
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        entry_t           wdata;
        logic [IDX_W-1:0] raddr;
    } tbl_req_t;

    // Load strobe into the response register
    typedef struct packed {
        logic      load;
        out_item_t item;
    } out_load_t;

endpackage

FILE: hdl/rtll_table.sv
module rtll_table (
    input  logic              clk,
    input  rtll_pkg::tbl_req_t tbl,
    output rtll_pkg::entry_t   rd_data
);
    import rtll_pkg::*;

    entry_t mem_reg [TABLE_DEPTH];
    entry_t rd_data_reg;

    // Single write port
    always_ff @(posedge clk)
    begin
        if (tbl.we)
        begin
            mem_reg[tbl.waddr] <= tbl.wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem_reg[tbl.raddr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/rtll_out.sv
module rtll_out (
    input  logic                clk,
    input  logic                rst_n,
    input  rtll_pkg::out_load_t load,
    output logic                slot_free,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output rtll_pkg::out_item_t rsp
);
    import rtll_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_item_t data_reg;

    // Slot can take a new row when empty or draining this cycle
    assign slot_free = !valid_reg || rsp_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load.load)
        begin
            valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load.load)
        begin
            data_reg <= load.item;
        end
    end

    assign rsp_valid = valid_reg;
    assign rsp       = data_reg;

endmodule

FILE: hdl/rtll_seq.sv
module rtll_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  rtll_pkg::in_item_t  req,
    input  rtll_pkg::entry_t    rd_data,
    input  logic                slot_free,
    output rtll_pkg::tbl_req_t  tbl,
    output rtll_pkg::out_load_t load
);
    import rtll_pkg::*;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] n_reg, n_next;
    in_item_t         req_reg, req_next;
    out_item_t        res_reg, res_next;

    logic [CNT_W-1:0] idx_inc;
    logic             key_eq;
    logic             match_here;
    logic             at_end;
    logic [CMP_W-1:0] fill_ext, lim_ext, cap_ext, min_a, dump_ext;
    logic [CNT_W-1:0] dump_n;
    entry_t           wr_entry;

    // Dump length: min of fill count, request limit and result cap
    always_comb
    begin
        fill_ext = CMP_W'(fill_reg);
        lim_ext  = CMP_W'(req.dump_limit);
        cap_ext  = CMP_W'(RESULT_CAP);
        min_a    = (fill_ext < lim_ext) ? fill_ext : lim_ext;
        dump_ext = (min_a < cap_ext) ? min_a : cap_ext;
        dump_n   = dump_ext[CNT_W-1:0];
    end

    // Shared key compare against the entry read last cycle
    assign idx_inc    = idx_reg + CNT_W'(1);
    assign key_eq     = (rd_data.dev == req_reg.dev_key) &&
                        (rd_data.sub_a == req_reg.sub_key_a) &&
                        (rd_data.sub_b == req_reg.sub_key_b);
    assign match_here = (idx_reg < n_reg) && key_eq;
    assign at_end     = (idx_inc >= n_reg);

    // Entry image written on record
    always_comb
    begin
        wr_entry.dev     = req_reg.dev_key;
        wr_entry.sub_a   = req_reg.sub_key_a;
        wr_entry.sub_b   = req_reg.sub_key_b;
        wr_entry.channel = req_reg.route_channel;
        wr_entry.slot    = req_reg.route_slot;
        wr_entry.seen    = req_reg.time_now;
    end

    assign req_ready = (state_reg == ST_IDLE);

    // Next state and datapath controls
    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        idx_next   = idx_reg;
        n_next     = n_reg;
        req_next   = req_reg;
        res_next   = res_reg;
        tbl.we     = 1'b0;
        tbl.waddr  = idx_reg[IDX_W-1:0];
        tbl.wdata  = wr_entry;
        tbl.raddr  = '0;
        load.load  = 1'b0;
        load.item  = res_reg;

        case (state_reg)
            ST_IDLE:
            begin
                // entry 0 is read every idle cycle
                tbl.raddr = '0;
                if (req_valid)
                begin
                    req_next = req;
                    idx_next = '0;
                    case (req.func)
                        FN_RECORD, FN_LOOKUP:
                        begin
                            n_next     = fill_reg;
                            state_next = ST_SEARCH;
                        end
                        FN_DUMP:
                        begin
                            n_next = dump_n;
                            if (dump_n != '0)
                            begin
                                state_next = ST_DUMP;
                            end
                        end
                        FN_CLEAR:
                        begin
                            fill_next = '0;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_SEARCH:
            begin
                tbl.raddr = idx_inc[IDX_W-1:0];
                if (match_here)
                begin
                    if (req_reg.func == FN_RECORD)
                    begin
                        tbl.we     = 1'b1;
                        tbl.waddr  = idx_reg[IDX_W-1:0];
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        res_next             = '0;
                        res_next.hit         = 1'b1;
                        res_next.out_channel = rd_data.channel;
                        res_next.out_slot    = rd_data.slot;
                        res_next.out_seen    = rd_data.seen;
                        res_next.last_row    = 1'b1;
                        state_next           = ST_RESP;
                    end
                end
                else if (at_end)
                begin
                    if (req_reg.func == FN_RECORD)
                    begin
                        // append on a miss, drop when full
                        if (fill_reg < DEPTH_CNT)
                        begin
                            tbl.we    = 1'b1;
                            tbl.waddr = fill_reg[IDX_W-1:0];
                            fill_next = fill_reg + CNT_W'(1);
                        end
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        res_next          = '0;
                        res_next.last_row = 1'b1;
                        state_next        = ST_RESP;
                    end
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end

            ST_RESP:
            begin
                if (slot_free)
                begin
                    load.load  = 1'b1;
                    load.item  = res_reg;
                    state_next = ST_IDLE;
                end
            end

            ST_DUMP:
            begin
                // hold the read address while the response slot is busy
                tbl.raddr = idx_reg[IDX_W-1:0];
                if (slot_free)
                begin
                    tbl.raddr             = idx_inc[IDX_W-1:0];
                    load.load             = 1'b1;
                    load.item.hit         = 1'b1;
                    load.item.out_dev     = rd_data.dev;
                    load.item.out_sub_a   = rd_data.sub_a;
                    load.item.out_sub_b   = rd_data.sub_b;
                    load.item.out_channel = rd_data.channel;
                    load.item.out_slot    = rd_data.slot;
                    load.item.out_seen    = rd_data.seen;
                    load.item.last_row    = (idx_inc == n_reg);
                    if (idx_inc == n_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_inc;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            idx_reg   <= '0;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            idx_reg   <= idx_next;
            n_reg     <= n_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        res_reg <= res_next;
    end

endmodule

FILE: hdl/route_table_learn_and_lookup_core.sv
// Record/lookup: after the accept, entries are compared from index 0 up to the fill count
//   (at most 32), stopping at the first key match; a lookup then loads the response register.
// Dump: after the accept, one row per cycle while the response side keeps draining.
// The single table read port sets the one-entry-per-cycle pace, stalled only in a dump.
// Reset clears the sequencer, the fill count and the response valid; table contents
//   are left as is and are only ever used below the fill count.
module route_table_learn_and_lookup_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  rtll_pkg::in_item_t  req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output rtll_pkg::out_item_t rsp
);
    import rtll_pkg::*;

    tbl_req_t  tbl;
    entry_t    rd_data;
    out_load_t load;
    logic      slot_free;

    rtll_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rd_data   (rd_data),
        .slot_free (slot_free),
        .tbl       (tbl),
        .load      (load)
    );

    rtll_table u_table (
        .clk     (clk),
        .tbl     (tbl),
        .rd_data (rd_data)
    );

    rtll_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .slot_free (slot_free),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule
